### rtl/lfc_pkg.sv
// Shared types and constants for the low-pass feedback comb filter.
// No dependencies; every other file of the block imports this package.
package lfc_pkg;

    // Fixed field widths of the channels and the configuration port
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int COEF_FRAC   = 14;
    localparam int LEN_REG_W   = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_GAIN  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LP_INPUT_COEF  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LP_FB_COEF     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DELAY_LENGTH   = 2'd3;

    // Register reset values
    localparam logic signed [COEF_W-1:0] FEEDBACK_GAIN_RESET = 16'sd0;
    localparam logic signed [COEF_W-1:0] LP_INPUT_COEF_RESET = 16'sd16384;
    localparam logic signed [COEF_W-1:0] LP_FB_COEF_RESET    = 16'sd0;
    localparam logic [LEN_REG_W-1:0]     DELAY_LENGTH_RESET  = 13'd4096;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;   // take the item, read the delay line
        logic mul;      // form a0*y and b0*lp_prev
        logic lp;       // sum and saturate the low-pass
        logic fb;       // form g*lp
        logic wr;       // write the delay line, advance, load the output
    } lfc_cmd_t;

endpackage

### rtl/lfc_if.sv
// Handshake channels of the comb filter: input sample and output sample.
// Depends on lfc_pkg for the sample width.
interface lfc_in_if;
    import lfc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface lfc_out_if;
    import lfc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

### rtl/lfc_ctrl.sv
// Sequencer of the comb filter: steps one item through read, multiply,
// low-pass, feedback and write. Depends on lfc_pkg for the command struct.
module lfc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output lfc_pkg::lfc_cmd_t cmd
);
    import lfc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_LP   = 3'd2;
    localparam logic [2:0] ST_FB   = 3'd3;
    localparam logic [2:0] ST_WR   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_LP;
            end
            ST_LP:
            begin
                cmd.lp     = 1'b1;
                state_next = ST_FB;
            end
            ST_FB:
            begin
                cmd.fb     = 1'b1;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                // hold until the output register can take the result
                if (slot_free)
                begin
                    cmd.wr     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.wr)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |-> (!out_valid_reg || out_ready))
        else $error("delay line written while the output register is occupied");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> cmd.mul)
        else $error("accepted item did not move on to the multiply step");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.wr))
        else $error("output valid rose without a write step");

endmodule

### rtl/lfc_datapath.sv
// Datapath of the comb filter: configuration registers, delay-line memory,
// multiplier, saturating adders and pointer. Depends on lfc_pkg.
module lfc_datapath
#(
    parameter int MAX_DELAY   = 4096,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_wen,
    input  logic [lfc_pkg::CFG_INDEX_W-1:0]           cfg_index,
    input  logic [lfc_pkg::CFG_DATA_W-1:0]            cfg_data,
    input  logic signed [lfc_pkg::SAMPLE_W-1:0]       sample_in,
    input  lfc_pkg::lfc_cmd_t                         cmd,
    output logic signed [lfc_pkg::SAMPLE_W-1:0]       sample_out
);
    import lfc_pkg::*;

    localparam int PTR_W  = $clog2(MAX_DELAY);
    localparam int FILL_W = $clog2(MAX_DELAY + 1);
    localparam int LEN_W  = (FILL_W > LEN_REG_W) ? FILL_W : LEN_REG_W;
    localparam int PROD_W = COEF_W + SAMPLE_BITS;
    localparam int WIDE_W = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int SUM_W  = WIDE_W + 3;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_DELAY);

    function automatic logic signed [SAMPLE_BITS-1:0] sat(
        input logic signed [SUM_W-1:0] v);
        logic signed [SAMPLE_BITS-1:0] r;
        priority if (v > SAT_HI)
            r = SAT_HI[SAMPLE_BITS-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[SAMPLE_BITS-1:0];
        else
            r = v[SAMPLE_BITS-1:0];
        return r;
    endfunction

    // configuration
    logic signed [COEF_W-1:0]      gain_reg;
    logic signed [COEF_W-1:0]      a0_reg;
    logic signed [COEF_W-1:0]      b0_reg;
    logic [LEN_REG_W-1:0]          len_reg;

    // state and work registers
    logic [PTR_W-1:0]              ptr_reg;
    logic [PTR_W-1:0]              ptr_next;
    logic [FILL_W-1:0]             fill_reg;
    logic [FILL_W-1:0]             fill_next;
    logic signed [SAMPLE_BITS-1:0] lp_reg;
    logic signed [SAMPLE_W-1:0]    x_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic signed [SAMPLE_BITS-1:0] y_next;
    logic signed [SAMPLE_BITS-1:0] rdata_reg;
    logic                          hit_reg;
    logic signed [PROD_W-1:0]      prod_a_reg;
    logic signed [PROD_W-1:0]      prod_b_reg;
    logic signed [SAMPLE_W-1:0]    out_reg;

    logic signed [SAMPLE_BITS-1:0] mem [MAX_DELAY];

    logic [FILL_W-1:0]             ptr_ext;
    logic [LEN_W-1:0]              len_ext;
    logic [LEN_W-1:0]              len_act;
    logic [LEN_W-1:0]              ptr_inc;
    logic signed [SUM_W-1:0]       lp_sum;
    logic signed [SUM_W-1:0]       w_sum;
    logic signed [SAMPLE_BITS-1:0] w_val;

    assign ptr_ext = FILL_W'(ptr_reg);
    assign len_ext = LEN_W'(len_reg);
    assign ptr_inc = LEN_W'(ptr_reg) + LEN_W'(1);

    always_comb
    begin
        priority if (len_ext == '0)
            len_act = LEN_W'(1);
        else if (len_ext > MAX_LEN)
            len_act = MAX_LEN;
        else
            len_act = len_ext;
    end

    // entries at or above the fill count were never written and read as zero
    assign y_next = hit_reg ? rdata_reg : '0;

    assign lp_sum = SUM_W'(prod_a_reg >>> COEF_FRAC) + SUM_W'(prod_b_reg >>> COEF_FRAC);
    assign w_sum  = SUM_W'(x_reg) + SUM_W'(prod_a_reg >>> COEF_FRAC);
    assign w_val  = sat(w_sum);

    always_comb
    begin
        ptr_next  = ptr_reg;
        fill_next = fill_reg;
        if (cmd.wr)
        begin
            // wrap when the advanced pointer reaches or passes the length
            if (ptr_inc >= len_act)
                ptr_next = '0;
            else
                ptr_next = ptr_inc[PTR_W-1:0];
            if (ptr_ext == fill_reg)
                fill_next = fill_reg + FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= FEEDBACK_GAIN_RESET;
            a0_reg   <= LP_INPUT_COEF_RESET;
            b0_reg   <= LP_FB_COEF_RESET;
            len_reg  <= DELAY_LENGTH_RESET;
            ptr_reg  <= '0;
            fill_reg <= '0;
            lp_reg   <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                unique case (cfg_index)
                    REG_FEEDBACK_GAIN: gain_reg <= cfg_data;
                    REG_LP_INPUT_COEF: a0_reg   <= cfg_data;
                    REG_LP_FB_COEF:    b0_reg   <= cfg_data;
                    REG_DELAY_LENGTH:  len_reg  <= cfg_data[LEN_REG_W-1:0];
                    default:           ;
                endcase
            end
            ptr_reg  <= ptr_next;
            fill_reg <= fill_next;
            if (cmd.lp)
                lp_reg <= sat(lp_sum);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            x_reg   <= sample_in;
            hit_reg <= (ptr_ext < fill_reg);
        end
        if (cmd.mul)
        begin
            y_reg      <= y_next;
            prod_a_reg <= a0_reg * y_next;
            prod_b_reg <= b0_reg * lp_reg;
        end
        if (cmd.fb)
            prod_a_reg <= gain_reg * lp_reg;
        if (cmd.wr)
            out_reg <= SAMPLE_W'(y_reg);
    end

    // delay line
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
            mem[ptr_reg] <= w_val;
        if (cmd.accept)
            rdata_reg <= mem[ptr_reg];
    end

    assign sample_out = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        ptr_ext <= fill_reg)
        else $error("write pointer ran ahead of the fill count");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |=> (fill_reg > FILL_W'($past(ptr_reg))))
        else $error("written entry not covered by the fill count");

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

endmodule

### rtl/lowpass_feedback_comb_filter_core.sv
// Top level of the low-pass feedback comb filter.
// Depends on lfc_pkg, lfc_if, lfc_ctrl and lfc_datapath.

// One item holds one signed Q1.15 sample; for each item the block returns the
// delay-line sample written delay_length items earlier (zero until written),
// runs it through the one-pole low-pass and writes x + g*lp back. An item steps
// through accept with the delay-line read, the two low-pass products, the
// saturating low-pass sum, the feedback product, and the write; the sequence
// is set by the single read/write port of the delay memory. in_ch.ready is
// high only between items. The result sits in an output register, so the next
// item is accepted while it waits; the write step holds only if the previous
// result has still not been taken.
// The delay memory needs no clearing pass after reset: a fill count marks the
// entries written so far and the rest read as zero.
module lowpass_feedback_comb_filter_core
#(
    parameter int MAX_DELAY   = 4096,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wen,
    input  logic [lfc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lfc_pkg::CFG_DATA_W-1:0]   cfg_data,
    lfc_in_if.sink                           in_ch,
    lfc_out_if.source                        out_ch
);
    import lfc_pkg::*;

    lfc_cmd_t cmd;

    lfc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    lfc_datapath
    #(
        .MAX_DELAY   (MAX_DELAY),
        .SAMPLE_BITS (SAMPLE_BITS)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (in_ch.sample_in),
        .cmd        (cmd),
        .sample_out (out_ch.sample_out)
    );

endmodule
